// ===== rtl/core/ritter_bounding_sphere_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef RITTER_BOUNDING_SPHERE_UNIT_MACROS_SVH
`define RITTER_BOUNDING_SPHERE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RBS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rbs_pkg.sv =====
package rbs_pkg;

  localparam int COORD_W    = 32;
  localparam int RAD_W      = 33;
  localparam int PROD_W     = 2 * RAD_W;
  localparam int SUM_W      = 66;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int DIV_STEPS  = PROD_W;
  localparam int SQ_REM_W   = RAD_W + 3;
  localparam int SQ_CNT_W   = $clog2(SQRT_STEPS);
  localparam int DV_CNT_W   = $clog2(DIV_STEPS);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RAD_W-1:0] radius_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SPAN_MUL,
    ST_SPAN_ADD,
    ST_PICK,
    ST_CENTER,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_SQRT,
    ST_SQ_DONE,
    ST_READ,
    ST_LATCH,
    ST_PT_MUL,
    ST_PT_ADD,
    ST_RR_MUL,
    ST_CMP,
    ST_GROW,
    ST_DIV_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_UPD,
    ST_NEXT,
    ST_EMIT
  } rbs_state_t;

endpackage

// ===== rtl/core/rbs_vertex_if.sv =====
interface rbs_vertex_if;
  import rbs_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  coord_t vertex_z;
  logic   last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                  output last_vertex, input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
                input last_vertex, output ready);
endinterface

// ===== rtl/core/rbs_sphere_if.sv =====
interface rbs_sphere_if;
  import rbs_pkg::*;

  logic    valid;
  logic    ready;
  coord_t  center_x;
  coord_t  center_y;
  coord_t  center_z;
  radius_t sphere_radius;
  logic    overflowed;

  modport source (output valid, output center_x, output center_y, output center_z,
                  output sphere_radius, output overflowed, input ready);
  modport sink (input valid, input center_x, input center_y, input center_z,
                input sphere_radius, input overflowed, output ready);
endinterface

// ===== rtl/core/rbs_ram.sv =====
module rbs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic [AW-1:0]           raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/ritter_bounding_sphere_unit.sv =====
// Ritter bounding sphere over a set of signed Q16.16 vertices.
// Input channel (vertex): one vertex per transaction, last_vertex closes the set.
// Output channel (sphere): one transaction per set with center, radius (Q17.16)
// and a flag telling that vertices past MAX_VERTICES were dropped.
// Loading accepts one vertex per cycle; vertices are written to one vertex RAM
// while per-axis extreme vertices are tracked in registers.
// After the last vertex, ready drops and a sequencer runs a shared 33x33
// multiplier, a 33-step square root and a 66-step restoring divider:
//   it seeds the sphere, then sweeps each stored vertex
//   (RAM read, three squares, r*r, compare), with a square root and three
//   divides for each vertex that grows the sphere.
// The result goes to an output register; the block returns to loading as soon
// as that register is free, so a stalled receiver only holds the next finish.
// A result waiting in the output register does not stop the next set loading.
// Reset (rst, synchronous) empties the set, clears the drop flag and the output
// valid; the RAM needs no clearing since only entries of the current set are read.
module ritter_bounding_sphere_unit #(
  parameter int MAX_VERTICES = 1024
) (
  input logic          clk,
  input logic          rst,
  rbs_vertex_if.sink   vertex,
  rbs_sphere_if.source sphere
);
  import rbs_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  rbs_state_t state, state_next;

  logic [CW-1:0] count;
  logic          drop;
  logic [AW-1:0] idx;
  logic [1:0]    ax;
  logic [1:0]    k;
  logic          grow;

  coord_t lo_v [3][3];
  coord_t hi_v [3][3];
  coord_t p_v [3];
  coord_t center [3];
  coord_t vin [3];

  logic [SUM_W-1:0]  span [3];
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  acc_sum;
  logic [PROD_W-1:0] prod;
  radius_t           radius;
  radius_t           new_r;
  radius_t           delta;

  logic [SUM_W-1:0]    sq_n;
  radius_t             sq_root;
  logic [SQ_REM_W-1:0] sq_rem;
  logic [SQ_REM_W-1:0] sq_shift;
  logic [SQ_REM_W-1:0] sq_trial;
  logic [SQ_CNT_W-1:0] sq_cnt;

  logic [PROD_W-1:0]   dv_num;
  radius_t             dv_rem;
  logic [RAD_W:0]      dv_shift;
  logic [DV_CNT_W-1:0] dv_cnt;

  coord_t            op_a, op_b;
  logic signed [32:0] diff;
  radius_t           mag;
  radius_t           mul_a, mul_b;
  logic [33:0]       c_ext, q_ext, c_upd;
  logic signed [32:0] mid_sum;

  logic    ram_we;
  vertex_t ram_wdata, ram_rdata;
  logic    in_fire, out_free, has_room;

  assign vin[0] = vertex.vertex_x;
  assign vin[1] = vertex.vertex_y;
  assign vin[2] = vertex.vertex_z;

  assign in_fire  = vertex.valid && vertex.ready;
  assign out_free = !sphere.valid || sphere.ready;
  assign has_room = count < CW'(MAX_VERTICES);

  assign ram_we    = in_fire && has_room;
  assign ram_wdata = '{x: vertex.vertex_x, y: vertex.vertex_y, z: vertex.vertex_z};

  rbs_ram #(.WIDTH($bits(vertex_t)), .DEPTH(MAX_VERTICES)) u_vertex_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Operand selection for the shared difference/magnitude path.
  always_comb begin
    unique case (state)
      ST_SPAN_MUL: begin
        op_a = hi_v[ax][k];
        op_b = lo_v[ax][k];
      end
      ST_SEED_MUL: begin
        op_a = lo_v[ax][k];
        op_b = center[k];
      end
      default: begin
        op_a = p_v[k];
        op_b = center[k];
      end
    endcase
  end

  assign diff  = 33'(op_a) - 33'(op_b);
  assign mag   = diff[32] ? radius_t'(~diff + 33'sd1) : radius_t'(diff);
  assign mul_a = (state == ST_RR_MUL) ? radius : mag;
  assign mul_b = (state == ST_RR_MUL) ? radius :
                 (state == ST_DIV_MUL) ? delta : mag;

  assign acc_sum = ((k == 2'd0) ? '0 : acc) + prod;
  assign delta   = new_r - radius;

  assign sq_shift = {sq_rem[SQ_REM_W-3:0], sq_n[SUM_W-1 -: 2]};
  assign sq_trial = SQ_REM_W'({sq_root, 2'b01});
  assign dv_shift = {dv_rem, dv_num[PROD_W-1]};

  assign mid_sum = 33'(lo_v[ax][k]) + 33'(hi_v[ax][k]);
  assign c_ext   = 34'(center[k]);
  assign q_ext   = {1'b0, dv_num[RAD_W-1:0]};
  assign c_upd   = diff[32] ? (c_ext - q_ext) : (c_ext + q_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    vertex.ready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        vertex.ready = 1'b1;
        if (in_fire && vertex.last_vertex) state_next = ST_SPAN_MUL;
      end
      ST_SPAN_MUL: state_next = ST_SPAN_ADD;
      ST_SPAN_ADD: state_next = (k == 2'd2 && ax == 2'd2) ? ST_PICK : ST_SPAN_MUL;
      ST_PICK:     state_next = ST_CENTER;
      ST_CENTER:   state_next = (k == 2'd2) ? ST_SEED_MUL : ST_CENTER;
      ST_SEED_MUL: state_next = ST_SEED_ADD;
      ST_SEED_ADD: state_next = (k == 2'd2) ? ST_SQRT : ST_SEED_MUL;
      ST_SQRT:     state_next = (sq_cnt == SQ_CNT_W'(SQRT_STEPS - 1)) ? ST_SQ_DONE : ST_SQRT;
      ST_SQ_DONE:  state_next = grow ? ST_GROW : ST_READ;
      ST_READ:     state_next = ST_LATCH;
      ST_LATCH:    state_next = ST_PT_MUL;
      ST_PT_MUL:   state_next = ST_PT_ADD;
      ST_PT_ADD:   state_next = (k == 2'd2) ? ST_RR_MUL : ST_PT_MUL;
      ST_RR_MUL:   state_next = ST_CMP;
      ST_CMP:      state_next = (acc > prod) ? ST_SQRT : ST_NEXT;
      ST_GROW:     state_next = ST_DIV_MUL;
      ST_DIV_MUL:  state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV:      state_next = (dv_cnt == DV_CNT_W'(DIV_STEPS - 1)) ? ST_UPD : ST_DIV;
      ST_UPD:      state_next = (k == 2'd2) ? ST_NEXT : ST_DIV_MUL;
      ST_NEXT:     state_next = (CW'(idx) + CW'(1) == count) ? ST_EMIT : ST_READ;
      ST_EMIT:     state_next = out_free ? ST_LOAD : ST_EMIT;
      default:     state_next = ST_LOAD;
    endcase
  end

  // Set bookkeeping and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      drop         <= 1'b0;
      sphere.valid <= 1'b0;
    end else begin
      if (sphere.valid && sphere.ready) sphere.valid <= 1'b0;
      if (state == ST_LOAD && in_fire) begin
        if (has_room) begin
          count <= count + CW'(1);
        end else begin
          drop <= 1'b1;
        end
      end
      if (state == ST_EMIT && out_free) begin
        sphere.valid <= 1'b1;
        count        <= '0;
        drop         <= 1'b0;
      end
    end
  end

  // Datapath: shared multiplier, accumulator, square root and divider.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    unique case (state)
      ST_LOAD: begin
        if (in_fire && has_room) begin
          for (int a = 0; a < 3; a++) begin
            if (count == '0 || vin[a] < lo_v[a][a]) begin
              for (int j = 0; j < 3; j++) lo_v[a][j] <= vin[j];
            end
            if (count == '0 || vin[a] > hi_v[a][a]) begin
              for (int j = 0; j < 3; j++) hi_v[a][j] <= vin[j];
            end
          end
        end
        ax <= '0;
        k  <= '0;
      end
      ST_SPAN_ADD: begin
        acc <= acc_sum;
        if (k == 2'd2) begin
          span[ax] <= acc_sum;
          k        <= '0;
          ax       <= ax + 2'd1;
        end else begin
          k <= k + 2'd1;
        end
      end
      ST_PICK: begin
        // Ties for the widest span fall back to x.
        if (span[1] > span[0] && span[1] > span[2]) begin
          ax <= 2'd1;
        end else if (span[2] > span[0] && span[2] > span[1]) begin
          ax <= 2'd2;
        end else begin
          ax <= 2'd0;
        end
        k <= '0;
      end
      ST_CENTER: begin
        center[k] <= mid_sum[32:1];
        k         <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      ST_SEED_ADD, ST_PT_ADD: begin
        acc <= acc_sum;
        if (k == 2'd2) begin
          k       <= '0;
          sq_n    <= acc_sum;
          sq_root <= '0;
          sq_rem  <= '0;
          sq_cnt  <= '0;
          grow    <= 1'b0;
        end else begin
          k <= k + 2'd1;
        end
      end
      ST_SQRT: begin
        if (sq_shift >= sq_trial) begin
          sq_rem  <= sq_shift - sq_trial;
          sq_root <= {sq_root[RAD_W-2:0], 1'b1};
        end else begin
          sq_rem  <= sq_shift;
          sq_root <= {sq_root[RAD_W-2:0], 1'b0};
        end
        sq_n   <= sq_n << 2;
        sq_cnt <= sq_cnt + SQ_CNT_W'(1);
      end
      ST_SQ_DONE: begin
        if (!grow) begin
          radius <= sq_root;
          idx    <= '0;
        end
      end
      ST_LATCH: begin
        p_v[0] <= ram_rdata.x;
        p_v[1] <= ram_rdata.y;
        p_v[2] <= ram_rdata.z;
        k      <= '0;
      end
      ST_CMP: begin
        // acc still holds the squared distance; restart the root on it.
        sq_n    <= acc;
        sq_root <= '0;
        sq_rem  <= '0;
        sq_cnt  <= '0;
        grow    <= 1'b1;
      end
      ST_GROW: begin
        new_r <= radius_t'(({1'b0, radius} + {1'b0, sq_root}) >> 1);
        k     <= '0;
      end
      ST_DIV_LOAD: begin
        dv_num <= prod;
        dv_rem <= '0;
        dv_cnt <= '0;
      end
      ST_DIV: begin
        if (dv_shift >= {1'b0, sq_root}) begin
          dv_rem <= radius_t'(dv_shift - {1'b0, sq_root});
          dv_num <= {dv_num[PROD_W-2:0], 1'b1};
        end else begin
          dv_rem <= dv_shift[RAD_W-1:0];
          dv_num <= {dv_num[PROD_W-2:0], 1'b0};
        end
        dv_cnt <= dv_cnt + DV_CNT_W'(1);
      end
      ST_UPD: begin
        // Move toward the point by the truncated quotient.
        center[k] <= c_upd[COORD_W-1:0];
        if (k == 2'd2) begin
          k      <= '0;
          radius <= new_r;
        end else begin
          k <= k + 2'd1;
        end
      end
      ST_NEXT: begin
        idx <= idx + AW'(1);
      end
      ST_EMIT: begin
        if (out_free) begin
          sphere.center_x      <= center[0];
          sphere.center_y      <= center[1];
          sphere.center_z      <= center[2];
          sphere.sphere_radius <= radius;
          sphere.overflowed    <= drop;
        end
      end
      default: begin
      end
    endcase
  end
endmodule

// ===== rtl/core/rbs_checker.sv =====
`include "ritter_bounding_sphere_unit_macros.svh"

module rbs_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_last,
  input logic           out_valid,
  input logic           out_ready,
  input rbs_pkg::coord_t  center_x,
  input rbs_pkg::coord_t  center_y,
  input rbs_pkg::coord_t  center_z,
  input rbs_pkg::radius_t sphere_radius,
  input logic           overflowed
);
  import rbs_pkg::*;

  // A stalled result holds.
  `RBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(center_x) && $stable(center_y) && $stable(center_z) && $stable(sphere_radius) && $stable(overflowed), "result changed while stalled")

  // Closing a set stops intake while the sphere is computed.
  `RBS_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && in_last, !in_ready, "vertex taken during compute")

  // A new result appears only out of the compute phase.
  `RBS_ASSERT(a_result_from_compute, $rose(out_valid), $past(!in_ready), "result without compute")
endmodule

bind ritter_bounding_sphere_unit rbs_checker u_rbs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (vertex.valid),
  .in_ready      (vertex.ready),
  .in_last       (vertex.last_vertex),
  .out_valid     (sphere.valid),
  .out_ready     (sphere.ready),
  .center_x      (sphere.center_x),
  .center_y      (sphere.center_y),
  .center_z      (sphere.center_z),
  .sphere_radius (sphere.sphere_radius),
  .overflowed    (sphere.overflowed)
);

// ===== dv/ritter_bounding_sphere_unit_tb.sv =====
`timescale 1ns / 1ps

module ritter_bounding_sphere_unit_tb;
  import rbs_pkg::*;

  localparam int VERTEX_CAP = 1024;
  localparam int TOTAL_ITEMS = 1450;
  localparam coord_t C_MIN = 32'sh80000000;
  localparam coord_t C_MAX = 32'sh7fffffff;

  typedef logic signed [63:0] wcoord_t;
  typedef wcoord_t triple_t[3];

  typedef struct {
    coord_t  cx;
    coord_t  cy;
    coord_t  cz;
    radius_t r;
    logic    ovf;
  } sphere_t;

  typedef struct {
    coord_t  x;
    coord_t  y;
    coord_t  z;
    logic    last;
    logic    typed;
    sphere_t want;
  } vec_row_t;

  logic clk;
  logic rst;
  logic steady;
  int   fails;

  rbs_vertex_if vtx();
  rbs_sphere_if sph();

  ritter_bounding_sphere_unit #(.MAX_VERTICES(VERTEX_CAP)) uut (
    .clk(clk),
    .rst(rst),
    .vertex(vtx),
    .sphere(sph)
  );

  // Predictor state: the vertex set being loaded and its per-axis extremes.
  coord_t  xs[VERTEX_CAP];
  coord_t  ys[VERTEX_CAP];
  coord_t  zs[VERTEX_CAP];
  int      set_count;
  int      extreme[6];
  logic    dropped;
  sphere_t sphere_q[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end

  function automatic triple_t fetch(input int i);
    triple_t v;
    v[0] = xs[i];
    v[1] = ys[i];
    v[2] = zs[i];
    return v;
  endfunction

  function automatic logic [63:0] magnitude(input wcoord_t v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [127:0] dist_sq(input triple_t a, input triple_t b);
    logic [127:0] acc;
    logic [127:0] m;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      m = {64'b0, magnitude(a[k] - b[k])};
      acc += m * m;
    end
    return acc;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [63:0] res;
    logic [127:0] c;
    res = '0;
    for (int b = 40; b >= 0; b--) begin
      c = {64'b0, res | (64'd1 << b)};
      if (c * c <= n) res = c[63:0];
    end
    return res;
  endfunction

  // Seed on the widest extreme pair, then sweep every stored vertex once.
  function automatic sphere_t bound_set();
    triple_t lo[3];
    triple_t hi[3];
    triple_t ctr;
    triple_t p;
    logic [127:0] span[3];
    logic [127:0] s;
    logic [63:0] rad;
    logic [63:0] d;
    logic [63:0] nr;
    logic [127:0] q;
    wcoord_t df;
    int ax;
    sphere_t res;
    for (int a = 0; a < 3; a++) begin
      lo[a] = fetch(extreme[2*a]);
      hi[a] = fetch(extreme[2*a+1]);
      span[a] = dist_sq(hi[a], lo[a]);
    end
    ax = 0;
    if (span[1] > span[0] && span[1] > span[2]) ax = 1;
    if (span[2] > span[0] && span[2] > span[1]) ax = 2;
    for (int k = 0; k < 3; k++) ctr[k] = (lo[ax][k] + hi[ax][k]) >>> 1;
    rad = floor_sqrt(dist_sq(lo[ax], ctr));
    for (int i = 0; i < set_count; i++) begin
      p = fetch(i);
      s = dist_sq(p, ctr);
      if (s > {64'b0, rad} * {64'b0, rad}) begin
        d = floor_sqrt(s);
        nr = (rad + d) >> 1;
        for (int k = 0; k < 3; k++) begin
          df = p[k] - ctr[k];
          q = ({64'b0, magnitude(df)} * {64'b0, nr - rad}) / {64'b0, d};
          ctr[k] = df < 0 ? ctr[k] - wcoord_t'(q[63:0]) : ctr[k] + wcoord_t'(q[63:0]);
        end
        rad = nr;
      end
    end
    res.cx = ctr[0][31:0];
    res.cy = ctr[1][31:0];
    res.cz = ctr[2][31:0];
    res.r = rad[32:0];
    res.ovf = dropped;
    return res;
  endfunction

  // Absorb one accepted vertex; returns 1 when it closes the set.
  function automatic logic absorb(input coord_t x, input coord_t y, input coord_t z,
                                  input logic last, output sphere_t res);
    coord_t v[3];
    triple_t e;
    triple_t f;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    if (set_count < VERTEX_CAP) begin
      xs[set_count] = x;
      ys[set_count] = y;
      zs[set_count] = z;
      if (set_count == 0) begin
        for (int k = 0; k < 6; k++) extreme[k] = 0;
      end else begin
        // Strict compares: the first occurrence of an extreme wins.
        for (int k = 0; k < 3; k++) begin
          e = fetch(extreme[2*k]);
          f = fetch(extreme[2*k+1]);
          if (v[k] < e[k]) extreme[2*k] = set_count;
          if (v[k] > f[k]) extreme[2*k+1] = set_count;
        end
      end
      set_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return 1'b0;
    res = bound_set();
    set_count = 0;
    for (int k = 0; k < 6; k++) extreme[k] = 0;
    dropped = 1'b0;
    return 1'b1;
  endfunction

  // Drive one vertex on the falling edge, with a random gap first outside the steady
  // stretch, and hold it until the block takes it.
  task automatic push_vertex(input coord_t x, input coord_t y, input coord_t z,
                             input logic last, input logic typed, input sphere_t want);
    sphere_t got;
    while (!steady && $urandom_range(0, 99) < 31) begin
      vtx.valid = 1'b0;
      @(negedge clk);
    end
    vtx.valid = 1'b1;
    vtx.vertex_x = x;
    vtx.vertex_y = y;
    vtx.vertex_z = z;
    vtx.last_vertex = last;
    do @(posedge clk); while (!vtx.ready);
    if (absorb(x, y, z, last, got)) sphere_q.push_back(typed ? want : got);
    @(negedge clk);
    vtx.valid = 1'b0;
  endtask

  function automatic coord_t pick_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(($urandom_range(0, 2000) - 1000) <<< 16);
      2: return coord_t'($urandom_range(0, 510) - 255);
      default: begin
        case ($urandom_range(0, 3))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Directed vectors; typed expectations only where the answer is obvious.
  vec_row_t dir_tbl[] = '{
    '{'0, '0, '0, 1'b1, 1'b1, '{'0, '0, '0, '0, 1'b0}},
    '{C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, '{C_MAX, C_MAX, C_MAX, '0, 1'b0}},
    '{C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, '{C_MIN, C_MIN, C_MIN, '0, 1'b0}},
    // full x range: seed center rounds down to -1, second point grows by zero
    '{C_MIN, '0, '0, 1'b0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    '{C_MAX, '0, '0, 1'b1, 1'b1, '{-1, '0, '0, 33'h7fffffff, 1'b0}},
    // x and y extremes share one pair, so their spans tie and x wins
    '{'0, -(5 <<< 16), '0, 1'b0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    '{1 <<< 16, 7 <<< 16, '0, 1'b0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    '{'0, '0, 3 <<< 16, 1'b1, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    // x and y spans tie: x wins
    '{'0, '0, '0, 1'b0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    '{1 <<< 16, 1 <<< 16, '0, 1'b1, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    // y and z tie above x: falls back to x with a degenerate pair
    '{'0, '0, '0, 1'b0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    '{'0, 4, 4, 1'b1, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    // all axes share one extreme pair and tie, so x wins; first occurrence kept
    '{3, 3, -(9 <<< 16), 1'b0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    '{3, 3, -(9 <<< 16), 1'b0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    '{1, 1, 20 <<< 16, 1'b0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    '{1, 1, 20 <<< 16, 1'b1, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    // off-axis point lies inside the seed sphere, no growth step
    '{-(100 <<< 16), 50 <<< 16, 7, 1'b0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    '{100 <<< 16, -(50 <<< 16), -7, 1'b0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
    '{'0, '0, 90 <<< 16, 1'b1, 1'b0, '{'0, '0, '0, '0, 1'b0}}
  };

  // Sphere receiver: random backpressure, none during the steady stretch.
  initial begin
    sph.ready = 1'b0;
    forever begin
      @(negedge clk);
      sph.ready = steady || ($urandom_range(0, 99) >= 31);
    end
  end

  // Compare every accepted sphere against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && sph.valid && sph.ready) begin
      if (sphere_q.size() == 0) begin
        $error("unexpected sphere transaction");
        fails++;
      end else begin
        sphere_t w;
        w = sphere_q.pop_front();
        if (sph.center_x !== w.cx) begin
          $error("center_x expected %0d actual %0d", w.cx, sph.center_x);
          fails++;
        end
        if (sph.center_y !== w.cy) begin
          $error("center_y expected %0d actual %0d", w.cy, sph.center_y);
          fails++;
        end
        if (sph.center_z !== w.cz) begin
          $error("center_z expected %0d actual %0d", w.cz, sph.center_z);
          fails++;
        end
        if (sph.sphere_radius !== w.r) begin
          $error("sphere_radius expected %0d actual %0d", w.r, sph.sphere_radius);
          fails++;
        end
        if (sph.overflowed !== w.ovf) begin
          $error("overflowed expected %0d actual %0d", w.ovf, sph.overflowed);
          fails++;
        end
      end
    end
  end

  initial begin
    int sent;
    int set_len;
    int mode;
    logic big_done;
    sphere_t none;
    none = '{'0, '0, '0, '0, 1'b0};
    fails = 0;
    steady = 1'b0;
    set_count = 0;
    dropped = 1'b0;
    for (int k = 0; k < 6; k++) extreme[k] = 0;
    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.vertex_z = '0;
    vtx.last_vertex = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tbl[i])
      push_vertex(dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z, dir_tbl[i].last,
                  dir_tbl[i].typed, dir_tbl[i].want);

    // Hold the sender until every directed sphere has drained.
    while (sphere_q.size() != 0) @(negedge clk);

    sent = 0;
    big_done = 1'b0;
    while (sent < TOTAL_ITEMS) begin
      steady = (sent >= 100 && sent < 260);
      // One oversized set past capacity; its last vertex is itself dropped.
      if (!big_done && sent >= 200) begin
        set_len = VERTEX_CAP + 3;
        big_done = 1'b1;
      end else begin
        set_len = $urandom_range(1, 12);
      end
      mode = $urandom_range(0, 3);
      for (int i = 0; i < set_len; i++) begin
        push_vertex(pick_coord($urandom_range(0, 9) == 0 ? 3 : mode),
                    pick_coord($urandom_range(0, 9) == 0 ? 3 : mode),
                    pick_coord($urandom_range(0, 9) == 0 ? 3 : mode),
                    i == set_len - 1, 1'b0, none);
        sent++;
      end
    end
    steady = 1'b0;

    while (sphere_q.size() != 0) @(negedge clk);
    repeat (500) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
